[src/inverse_trig_unit_assert.svh]
// assertion macros for the inverse trig unit checker
// expects signals named clock and reset in the scope that uses them
`ifndef INVERSE_TRIG_UNIT_ASSERT_SVH
`define INVERSE_TRIG_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define ITU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define ITU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/itu_pkg.sv]
// shared types, constants and the rotation angle table of the inverse trig unit
// no dependencies
package itu_pkg;

   localparam int ITERATIONS = 32;
   localparam int SQRT_STEPS = 32;

   localparam int ARG_W   = 32;
   localparam int ANGLE_W = 32;
   localparam int REM_W   = 63;
   localparam int ROOT_W  = 32;
   localparam int XY_W    = 52;
   localparam int Z_W     = 35;
   localparam int ZC_W    = 33;
   localparam int ZR_W    = 34;
   localparam int Q_W     = 30;

   localparam logic [ARG_W-1:0] ONE_Q16     = 32'h0001_0000;
   localparam logic [32:0]      CORDIC_UNIT = 33'h1_0000_0000;
   localparam logic [ZC_W-1:0]  PI_HALF_Z   = 33'd6746518852;
   localparam logic [ZR_W-1:0]  PI_Z        = 34'd13493037704;

   localparam logic [Q_W-1:0] PI_QUARTER_Q28 = 30'd210828714;
   localparam logic [Q_W-1:0] PI_HALF_Q28    = 30'd421657428;
   localparam logic [Q_W-1:0] PI_Q28         = 30'd843314857;

   typedef enum logic [1:0] {
      OP_ASIN = 2'd0,
      OP_ACOS = 2'd1,
      OP_ATAN = 2'd2
   } itu_op_type;

   // result forced to a constant instead of the rotation output
   typedef enum logic [2:0] {
      FIX_NONE,
      FIX_ZERO,
      FIX_QUARTER_PI,
      FIX_HALF_PI,
      FIX_PI
   } itu_fix_type;

   typedef struct packed {
      itu_op_type       op;
      logic             neg;
      logic             negate;
      logic             invalid;
      itu_fix_type      fix;
      logic [ARG_W-1:0] mag;
   } itu_side_type;

   // atan(2^-i) scaled by 2^32
   function automatic logic [31:0] step_angle(input int idx);
      logic [31:0] ang;
      case (idx)
         0:       ang = 32'd3373259426;
         1:       ang = 32'd1991351318;
         2:       ang = 32'd1052175346;
         3:       ang = 32'd534100635;
         4:       ang = 32'd268086748;
         5:       ang = 32'd134174063;
         6:       ang = 32'd67103403;
         7:       ang = 32'd33553749;
         8:       ang = 32'd16777131;
         9:       ang = 32'd8388597;
         10:      ang = 32'd4194303;
         11:      ang = 32'd2097152;
         default: ang = (idx <= 32) ? (32'd1 << (32 - idx)) : 32'd0;
      endcase
      return ang;
   endfunction

endpackage

[src/itu_front.sv]
// front end: argument decode, special cases and the 1 - x*x square-root operand
// depends on itu_pkg
module itu_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [1:0]                 in_action,
   input  logic signed [itu_pkg::ARG_W-1:0] in_arg,
   output logic                       out_valid,
   output logic [itu_pkg::REM_W-1:0]  out_rem,
   output itu_pkg::itu_side_type      out_side
);
   import itu_pkg::*;

   logic [ARG_W-1:0] mag;
   logic             neg;
   logic             over;
   logic             unit;
   itu_side_type     side_a_in;
   itu_side_type     side_a_ff;
   logic             valid_a_ff;

   logic [31:0]      m_sq;
   logic [32:0]      diff;
   logic [REM_W-1:0] rem_b_in;
   logic [REM_W-1:0] rem_b_ff;
   itu_side_type     side_b_ff;
   logic             valid_b_ff;

   always_comb begin
      neg  = in_arg[ARG_W-1];
      mag  = neg ? (ARG_W'(0) - $unsigned(in_arg)) : $unsigned(in_arg);
      over = mag > ONE_Q16;
      unit = mag == ONE_Q16;

      side_a_in.op      = OP_ATAN;
      side_a_in.neg     = neg;
      side_a_in.negate  = 1'b0;
      side_a_in.invalid = 1'b0;
      side_a_in.fix     = FIX_NONE;
      side_a_in.mag     = mag;

      unique case (in_action)
         OP_ASIN: begin
            side_a_in.op = OP_ASIN;
            if (over) begin
               side_a_in.invalid = 1'b1;
               side_a_in.fix     = FIX_ZERO;
            end else begin
               side_a_in.negate = neg;
               if (unit) side_a_in.fix = FIX_HALF_PI;
            end
         end
         OP_ACOS: begin
            side_a_in.op = OP_ACOS;
            if (over) begin
               side_a_in.invalid = 1'b1;
               side_a_in.fix     = FIX_ZERO;
            end else if (unit) begin
               side_a_in.fix = neg ? FIX_PI : FIX_ZERO;
            end
         end
         OP_ATAN: begin
            side_a_in.op     = OP_ATAN;
            side_a_in.negate = neg;
            if (unit) side_a_in.fix = FIX_QUARTER_PI;
         end
         default: begin
            side_a_in.invalid = 1'b1;
            side_a_in.fix     = FIX_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_a_ff <= 1'b0;
      else if (advance) valid_a_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) side_a_ff <= side_a_in;
   end

   // only magnitudes below one reach the root, so 16 bits are enough
   always_comb begin
      m_sq     = 32'(side_a_ff.mag[15:0]) * 32'(side_a_ff.mag[15:0]);
      diff     = 33'h1_0000_0000 - {1'b0, m_sq};
      rem_b_in = {diff, 30'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_b_ff <= 1'b0;
      else if (advance) valid_b_ff <= valid_a_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_b_ff  <= rem_b_in;
         side_b_ff <= side_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_rem   = rem_b_ff;
   assign out_side  = side_b_ff;

endmodule

[src/itu_sqrt.sv]
// pipelined integer square root, one result bit per stage, rounding down
// depends on itu_pkg
module itu_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [itu_pkg::REM_W-1:0]  in_rem,
   input  itu_pkg::itu_side_type      in_side,
   output logic                       out_valid,
   output logic [itu_pkg::ROOT_W-1:0] out_root,
   output itu_pkg::itu_side_type      out_side
);
   import itu_pkg::*;

   logic             valid_st [SQRT_STEPS+1];
   logic [REM_W-1:0] rem_st   [SQRT_STEPS+1];
   logic [REM_W-1:0] res_st   [SQRT_STEPS+1];
   itu_side_type     side_st  [SQRT_STEPS+1];

   logic             valid_ff [SQRT_STEPS];
   logic [REM_W-1:0] rem_ff   [SQRT_STEPS];
   logic [REM_W-1:0] res_ff   [SQRT_STEPS];
   itu_side_type     side_ff  [SQRT_STEPS];

   assign valid_st[0] = in_valid;
   assign rem_st[0]   = in_rem;
   assign res_st[0]   = '0;
   assign side_st[0]  = in_side;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [REM_W-1:0] STEP_BIT = REM_W'(1) << (2 * (SQRT_STEPS - 1 - k));

      logic [REM_W:0]   trial;
      logic             fits;
      logic [REM_W-1:0] rem_in;
      logic [REM_W-1:0] res_in;

      always_comb begin
         trial = {1'b0, res_st[k]} + {1'b0, STEP_BIT};
         fits  = {1'b0, rem_st[k]} >= trial;
         if (fits) begin
            rem_in = rem_st[k] - trial[REM_W-1:0];
            res_in = (res_st[k] >> 1) + STEP_BIT;
         end else begin
            rem_in = rem_st[k];
            res_in = res_st[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k] <= 1'b0;
         else if (advance) valid_ff[k] <= valid_st[k];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_st[k];
         end
      end

      assign valid_st[k+1] = valid_ff[k];
      assign rem_st[k+1]   = rem_ff[k];
      assign res_st[k+1]   = res_ff[k];
      assign side_st[k+1]  = side_ff[k];
   end

   assign out_valid = valid_st[SQRT_STEPS];
   assign out_root  = res_st[SQRT_STEPS][ROOT_W-1:0];
   assign out_side  = side_st[SQRT_STEPS];

endmodule

[src/itu_cordic.sv]
// vectoring rotation pipeline: sets up (x, y) per operation, one micro-rotation per stage
// depends on itu_pkg
module itu_cordic (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [itu_pkg::ROOT_W-1:0]  in_root,
   input  itu_pkg::itu_side_type       in_side,
   output logic                        out_valid,
   output logic signed [itu_pkg::Z_W-1:0] out_z,
   output itu_pkg::itu_side_type       out_side
);
   import itu_pkg::*;

   logic signed [XY_W-1:0] x0_in;
   logic signed [XY_W-1:0] y0_in;
   itu_side_type           side0_in;
   logic signed [XY_W-1:0] x0_ff;
   logic signed [XY_W-1:0] y0_ff;
   itu_side_type           side0_ff;
   logic                   valid0_ff;

   logic                   valid_st [ITERATIONS+1];
   logic signed [XY_W-1:0] x_st     [ITERATIONS+1];
   logic signed [XY_W-1:0] y_st     [ITERATIONS+1];
   logic signed [Z_W-1:0]  z_st     [ITERATIONS+1];
   itu_side_type           side_st  [ITERATIONS+1];

   logic                   valid_ff [ITERATIONS];
   logic signed [XY_W-1:0] x_ff     [ITERATIONS];
   logic signed [XY_W-1:0] y_ff     [ITERATIONS];
   logic signed [Z_W-1:0]  z_ff     [ITERATIONS];
   itu_side_type           side_ff  [ITERATIONS];

   always_comb begin
      x0_in    = '0;
      y0_in    = '0;
      side0_in = in_side;
      unique case (in_side.op)
         OP_ATAN: begin
            x0_in = XY_W'(CORDIC_UNIT);
            y0_in = XY_W'({in_side.mag, 16'b0});
         end
         OP_ASIN: begin
            x0_in = XY_W'({in_root, 16'b0});
            y0_in = XY_W'({in_side.mag[16:0], 31'b0});
         end
         OP_ACOS: begin
            x0_in = XY_W'({in_side.mag[16:0], 31'b0});
            y0_in = XY_W'({in_root, 16'b0});
         end
         default: ;
      endcase
      // degenerate vectors: on the x axis or on the y axis
      if (in_side.fix == FIX_NONE) begin
         if (y0_in == '0) side0_in.fix = FIX_ZERO;
         else if (x0_in == '0) side0_in.fix = FIX_HALF_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid0_ff <= 1'b0;
      else if (advance) valid0_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         side0_ff <= side0_in;
      end
   end

   assign valid_st[0] = valid0_ff;
   assign x_st[0]     = x0_ff;
   assign y_st[0]     = y0_ff;
   assign z_st[0]     = '0;
   assign side_st[0]  = side0_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      localparam logic signed [Z_W-1:0] STEP_ANG = Z_W'(step_angle(i));

      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [Z_W-1:0]  z_in;

      always_comb begin
         dx = y_st[i] >>> i;
         dy = x_st[i] >>> i;
         if (!y_st[i][XY_W-1]) begin
            x_in = x_st[i] + dx;
            y_in = y_st[i] - dy;
            z_in = z_st[i] + STEP_ANG;
         end else begin
            x_in = x_st[i] - dx;
            y_in = y_st[i] + dy;
            z_in = z_st[i] - STEP_ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i] <= 1'b0;
         else if (advance) valid_ff[i] <= valid_st[i];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_st[i];
         end
      end

      assign valid_st[i+1] = valid_ff[i];
      assign x_st[i+1]     = x_ff[i];
      assign y_st[i+1]     = y_ff[i];
      assign z_st[i+1]     = z_ff[i];
      assign side_st[i+1]  = side_ff[i];
   end

   assign out_valid = valid_st[ITERATIONS];
   assign out_z     = z_st[ITERATIONS];
   assign out_side  = side_st[ITERATIONS];

endmodule

[src/itu_back.sv]
// back end: clamp, arccosine reflection, rounding to Q4.28, constant results and sign
// depends on itu_pkg
module itu_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic signed [itu_pkg::Z_W-1:0] in_z,
   input  itu_pkg::itu_side_type          in_side,
   output logic                           out_valid,
   output logic signed [itu_pkg::ANGLE_W-1:0] out_angle,
   output logic                           out_invalid
);
   import itu_pkg::*;

   logic [ZC_W-1:0]           z_clamp;
   logic [ZR_W-1:0]           zr_in;
   logic [ZR_W-1:0]           zr_ff;
   itu_side_type              side_f1_ff;
   logic                      valid_f1_ff;

   logic [ZR_W-1:0]           rounded;
   logic [Q_W-1:0]            q_sel;
   logic signed [ANGLE_W-1:0] angle_in;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic                      invalid_ff;
   logic                      valid_f2_ff;

   always_comb begin
      if (in_z[Z_W-1]) z_clamp = '0;
      else if (in_z > $signed(Z_W'(PI_HALF_Z))) z_clamp = PI_HALF_Z;
      else z_clamp = in_z[ZC_W-1:0];

      // negative arccosine argument maps to pi minus the angle
      if (in_side.op == OP_ACOS && in_side.neg) zr_in = PI_Z - {1'b0, z_clamp};
      else zr_in = {1'b0, z_clamp};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_f1_ff <= 1'b0;
      else if (advance) valid_f1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zr_ff      <= zr_in;
         side_f1_ff <= in_side;
      end
   end

   always_comb begin
      // round half up from 32 to 28 fraction bits
      rounded = zr_ff + ZR_W'(8);
      case (side_f1_ff.fix)
         FIX_NONE:       q_sel = rounded[ZR_W-1:4];
         FIX_ZERO:       q_sel = '0;
         FIX_QUARTER_PI: q_sel = PI_QUARTER_Q28;
         FIX_HALF_PI:    q_sel = PI_HALF_Q28;
         FIX_PI:         q_sel = PI_Q28;
         default:        q_sel = '0;
      endcase
      if (side_f1_ff.negate) angle_in = ANGLE_W'(0) - ANGLE_W'(q_sel);
      else angle_in = ANGLE_W'(q_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_f2_ff <= 1'b0;
      else if (advance) valid_f2_ff <= valid_f1_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff   <= angle_in;
         invalid_ff <= side_f1_ff.invalid;
      end
   end

   assign out_valid   = valid_f2_ff;
   assign out_angle   = angle_ff;
   assign out_invalid = invalid_ff;

endmodule

[src/inverse_trig_unit.sv]
// inverse trig unit: arcsine, arccosine and arctangent of a Q16.16 argument
// top level; depends on itu_pkg, itu_front, itu_sqrt, itu_cordic, itu_back
//
// Request beats carry an operation code (0 arcsine, 1 arccosine, 2 arctangent)
// and a signed Q16.16 argument; each gives exactly one response beat with a
// signed Q4.28 angle in radians and an invalid flag (arcsine or arccosine of a
// magnitude above one, or the unused operation code; the angle is then zero).
// Responses leave in request order.
// A request passes through two front stages, a
// 32-stage square-root pipeline, a setup stage, one stage per rotation, two
// finishing stages and the output register.
// Throughput is one beat per cycle while req_ready is high; every stage is a
// register, so a new request enters each cycle whatever the operation.
// A two-entry output buffer sits behind the pipeline. When the receiver stalls,
// one more result lands in the spare entry, then req_ready drops and the whole
// pipeline holds; nothing is dropped or repeated. req_ready is high whenever
// the output register is empty.
// Synchronous reset empties the pipeline and the output buffer; the block
// keeps no other state.
module inverse_trig_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic signed [itu_pkg::ARG_W-1:0] req_arg_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [itu_pkg::ANGLE_W-1:0] rsp_angle,
   output logic                             rsp_invalid
);
   import itu_pkg::*;

   logic                      advance;

   logic                      front_valid;
   logic [REM_W-1:0]          front_rem;
   itu_side_type              front_side;

   logic                      sqrt_valid;
   logic [ROOT_W-1:0]         sqrt_root;
   itu_side_type              sqrt_side;

   logic                      cordic_valid;
   logic signed [Z_W-1:0]     cordic_z;
   itu_side_type              cordic_side;

   logic                      pipe_valid;
   logic signed [ANGLE_W-1:0] pipe_angle;
   logic                      pipe_invalid;

   logic                      incoming;
   logic                      take;
   logic                      load_out;
   logic                      load_hold;
   logic                      out_from_hold;
   logic                      out_valid_in;
   logic                      out_valid_ff;
   logic                      hold_valid_in;
   logic                      hold_valid_ff;
   logic signed [ANGLE_W-1:0] out_angle_ff;
   logic                      out_invalid_ff;
   logic signed [ANGLE_W-1:0] hold_angle_ff;
   logic                      hold_invalid_ff;

   // pipeline moves whenever the spare output entry is free
   assign advance   = !hold_valid_ff;
   assign req_ready = advance;

   itu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_action (req_action),
      .in_arg    (req_arg_value),
      .out_valid (front_valid),
      .out_rem   (front_rem),
      .out_side  (front_side)
   );

   itu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_rem    (front_rem),
      .in_side   (front_side),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   itu_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .in_root   (sqrt_root),
      .in_side   (sqrt_side),
      .out_valid (cordic_valid),
      .out_z     (cordic_z),
      .out_side  (cordic_side)
   );

   itu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (cordic_valid),
      .in_z        (cordic_z),
      .in_side     (cordic_side),
      .out_valid   (pipe_valid),
      .out_angle   (pipe_angle),
      .out_invalid (pipe_invalid)
   );

   always_comb begin
      incoming      = advance && pipe_valid;
      take          = out_valid_ff && rsp_ready;
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      load_out      = 1'b0;
      load_hold     = 1'b0;
      out_from_hold = 1'b0;
      if (incoming) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            load_out     = 1'b1;
         end else begin
            hold_valid_in = 1'b1;
            load_hold     = 1'b1;
         end
      end else if (take) begin
         if (hold_valid_ff) begin
            out_from_hold = 1'b1;
            hold_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_angle_ff   <= pipe_angle;
         out_invalid_ff <= pipe_invalid;
      end else if (out_from_hold) begin
         out_angle_ff   <= hold_angle_ff;
         out_invalid_ff <= hold_invalid_ff;
      end
      if (load_hold) begin
         hold_angle_ff   <= pipe_angle;
         hold_invalid_ff <= pipe_invalid;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_angle   = out_angle_ff;
   assign rsp_invalid = out_invalid_ff;

endmodule

[src/itu_checker.sv]
// port-level checks of the inverse trig unit, bound to the top level
// depends on itu_pkg and inverse_trig_unit_assert.svh
`include "inverse_trig_unit_assert.svh"

module itu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [itu_pkg::ANGLE_W-1:0] rsp_angle,
   input logic                               rsp_invalid
);
   import itu_pkg::*;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(PI_Q28);
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -ANGLE_MAX;

   `ITU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_angle) && $stable(rsp_invalid), "stalled result beat changed")
   `ITU_ASSERT_SAME(a_invalid_zero, rsp_valid && rsp_invalid, rsp_angle == '0, "invalid result has a nonzero angle")
   `ITU_ASSERT_SAME(a_angle_range, rsp_valid, (rsp_angle <= ANGLE_MAX) && (rsp_angle >= ANGLE_MIN), "angle beyond pi")
   `ITU_ASSERT_SAME(a_ready_when_empty, !rsp_valid, req_ready, "request side stalled with an empty output")

endmodule

bind inverse_trig_unit itu_checker u_itu_checker (.*);

[test/inverse_trig_unit_tb.sv]
// testbench for inverse_trig_unit: directed table then random beats, all checked in order against
// table values or an in-bench cordic/isqrt predictor; depends on itu_pkg and inverse_trig_unit
`timescale 1ns / 100ps

module testbench;
   import itu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int N_DIRECTED  = 24;
   localparam int N_RANDOM    = 730;
   localparam int DRAIN_AT    = 400;
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 100;

   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam logic [31:0] UNIT_ARG  = 32'h0001_0000;

   // angles in q4.28
   localparam logic [31:0] QUARTER_PI_ANGLE = 32'd210828714;
   localparam logic [31:0] HALF_PI_ANGLE    = 32'd421657428;
   localparam logic [31:0] PI_ANGLE         = 32'd843314857;
   // angles with 32 fraction bits, as the rotation accumulates them
   localparam longint unsigned RIGHT_ANGLE_FRAC    = 64'd6746518852;
   localparam longint unsigned STRAIGHT_ANGLE_FRAC = 64'd13493037704;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] arg;
      logic        known;
      logic [31:0] angle;
      logic        invalid;
   } stim_row_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        arg;
      logic signed [31:0] angle;
      logic               invalid;
   } trig_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = OP_ASIN;
   logic signed [31:0] req_arg_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_angle;
   logic rsp_invalid;

   trig_result_type angle_queue[$];
   int errors = 0;
   int rsp_seen = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit rsp_holding = 1'b0;
   bit hold_done = 1'b0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{OP_ASIN,   32'h0000_0000, 1'b1, 32'h0,          1'b0},
      '{OP_ACOS,   32'h0000_0000, 1'b1, HALF_PI_ANGLE,  1'b0},
      '{OP_ATAN,   32'h0000_0000, 1'b1, 32'h0,          1'b0},
      '{OP_ASIN,   UNIT_ARG,      1'b1, HALF_PI_ANGLE,  1'b0},
      '{OP_ASIN,   -UNIT_ARG,     1'b1, -HALF_PI_ANGLE, 1'b0},
      '{OP_ACOS,   UNIT_ARG,      1'b1, 32'h0,          1'b0},
      '{OP_ACOS,   -UNIT_ARG,     1'b1, PI_ANGLE,       1'b0},
      '{OP_ATAN,   UNIT_ARG,      1'b1, QUARTER_PI_ANGLE, 1'b0},
      '{OP_ATAN,   -UNIT_ARG,     1'b1, -QUARTER_PI_ANGLE, 1'b0},
      '{OP_ASIN,   UNIT_ARG + 1,  1'b1, 32'h0,          1'b1},
      '{OP_ACOS,   -UNIT_ARG - 1, 1'b1, 32'h0,          1'b1},
      '{OP_ASIN,   32'h7fff_ffff, 1'b1, 32'h0,          1'b1},
      '{OP_ACOS,   32'h8000_0000, 1'b1, 32'h0,          1'b1},
      '{OP_UNUSED, 32'h0000_0000, 1'b1, 32'h0,          1'b1},
      '{OP_UNUSED, 32'h7fff_ffff, 1'b1, 32'h0,          1'b1},
      '{OP_ATAN,   32'h7fff_ffff, 1'b0, 32'h0,          1'b0},
      '{OP_ATAN,   32'h8000_0000, 1'b0, 32'h0,          1'b0},
      '{OP_ATAN,   32'h0000_0001, 1'b0, 32'h0,          1'b0},
      '{OP_ATAN,   32'hffff_ffff, 1'b0, 32'h0,          1'b0},
      '{OP_ASIN,   32'h0000_ffff, 1'b0, 32'h0,          1'b0},
      '{OP_ACOS,   32'hffff_0001, 1'b0, 32'h0,          1'b0},
      '{OP_ASIN,   32'h0000_8000, 1'b0, 32'h0,          1'b0},
      '{OP_ACOS,   32'hffff_8000, 1'b0, 32'h0,          1'b0},
      '{OP_ATAN,   32'h0002_0000, 1'b0, 32'h0,          1'b0}
   };

   inverse_trig_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_arg_value (req_arg_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_angle     (rsp_angle),
      .rsp_invalid   (rsp_invalid)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // atan(2^-i) with 32 fraction bits
   function automatic longint unsigned arc_step(input int i);
      longint unsigned a;
      case (i)
         0:       a = 64'd3373259426;
         1:       a = 64'd1991351318;
         2:       a = 64'd1052175346;
         3:       a = 64'd534100635;
         4:       a = 64'd268086748;
         5:       a = 64'd134174063;
         6:       a = 64'd67103403;
         7:       a = 64'd33553749;
         8:       a = 64'd16777131;
         9:       a = 64'd8388597;
         10:      a = 64'd4194303;
         11:      a = 64'd2097152;
         default: a = (i <= 32) ? (64'd1 << (32 - i)) : 64'd0;
      endcase
      return a;
   endfunction

   // angle of a first-quadrant vector by vectoring rotation, clamped to [0, pi/2]
   function automatic longint unsigned vector_angle(input longint unsigned xs,
                                                    input longint unsigned ys);
      longint x, y, z, dx, dy;
      x = xs;
      y = ys;
      z = 0;
      if (ys == 0) return 0;
      if (xs == 0) return RIGHT_ANGLE_FRAC;
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(arc_step(i));
         end else begin
            x -= dx; y += dy; z -= longint'(arc_step(i));
         end
      end
      if (z < 0) z = 0;
      if (z > longint'(RIGHT_ANGLE_FRAC)) z = longint'(RIGHT_ANGLE_FRAC);
      return longint'(z);
   endfunction

   // integer square root, rounded down
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // sqrt(1 - m*m) in q31, m below one in q16.16
   function automatic longint unsigned cosine_leg(input longint unsigned m);
      longint unsigned d;
      d = (64'd1 << 32) - m * m;
      return floor_sqrt(d << 30);
   endfunction

   function automatic trig_result_type predict_angle(input logic [1:0] act,
                                                     input logic [31:0] arg);
      trig_result_type res;
      logic [31:0] mag;
      longint unsigned m, q, z;
      logic neg, negate;
      neg = arg[31];
      mag = neg ? -arg : arg;
      m = 64'(mag);
      q = 0;
      negate = 1'b0;
      res.action = act;
      res.arg = arg;
      res.invalid = 1'b0;
      case (act)
         OP_ATAN: begin
            if (m == UNIT_ARG) q = 64'(QUARTER_PI_ANGLE);
            else q = (vector_angle(64'd65536 << 16, m << 16) + 8) >> 4;
            negate = neg;
         end
         OP_ASIN: begin
            if (m > UNIT_ARG) res.invalid = 1'b1;
            else if (m == UNIT_ARG) q = 64'(HALF_PI_ANGLE);
            else q = (vector_angle(cosine_leg(m) << 16, m << 31) + 8) >> 4;
            negate = neg && !res.invalid;
         end
         OP_ACOS: begin
            if (m > UNIT_ARG) begin
               res.invalid = 1'b1;
            end else if (m == UNIT_ARG) begin
               q = neg ? 64'(PI_ANGLE) : 64'd0;
            end else begin
               z = vector_angle(m << 31, cosine_leg(m) << 16);
               if (neg) z = STRAIGHT_ANGLE_FRAC - z;
               q = (z + 8) >> 4;
            end
         end
         default: res.invalid = 1'b1;
      endcase
      res.angle = negate ? -q[31:0] : q[31:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [31:0] random_arg();
      logic [31:0] mag;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: mag = $urandom_range(0, 65536);
         4:          mag = $urandom;
         5:          mag = $urandom >> $urandom_range(0, 31);
         6:          mag = UNIT_ARG - $urandom_range(0, 300);
         7:          mag = $urandom_range(0, 64);
         8: begin
            case ($urandom_range(0, 4))
               0:       mag = 32'h0;
               1:       mag = UNIT_ARG;
               2:       mag = UNIT_ARG + 1;
               3:       mag = 32'h7fff_ffff;
               default: mag = 32'h8000_0000;
            endcase
         end
         default:    mag = UNIT_ARG + $urandom_range(1, 1000);
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [1:0] random_action();
      int r;
      r = $urandom_range(0, 15);
      if (r < 5) return OP_ASIN;
      if (r < 10) return OP_ACOS;
      if (r < 15) return OP_ATAN;
      return OP_UNUSED;
   endfunction

   // hold the beat until accepted, then file its expected result
   task automatic offer(input logic [1:0] act, input logic [31:0] arg,
                        input trig_result_type exp);
      req_valid <= 1'b1;
      req_action <= act;
      req_arg_value <= arg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      angle_queue.push_back(exp);
   endtask

   // bursts of random length with random gaps; no gaps while the receiver holds off
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 32);
         if (!rsp_holding && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (angle_queue.size() != 0);
   endtask

   initial begin
      trig_result_type exp;
      logic [1:0] act;
      logic [31:0] arg;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].known) begin
            exp.action = directed_rows[i].action;
            exp.arg = directed_rows[i].arg;
            exp.angle = directed_rows[i].angle;
            exp.invalid = directed_rows[i].invalid;
         end else begin
            exp = predict_angle(directed_rows[i].action, directed_rows[i].arg);
         end
         offer(directed_rows[i].action, directed_rows[i].arg, exp);
         pace();
      end
      drain();

      for (int n = 0; n < N_RANDOM; n++) begin
         act = random_action();
         arg = random_arg();
         offer(act, arg, predict_angle(act, arg));
         if (n == DRAIN_AT) drain();
         else pace();
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("[inverse_trig_unit] OK");
      else
         $display("[inverse_trig_unit] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      @(posedge clock);
      forever begin
         if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            // long hold-off so the pipeline fills and stalls the request side
            hold_done = 1'b1;
            rsp_holding = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_holding = 1'b0;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  rsp_ready <= 1'b1;
                  repeat ($urandom_range(20, 80)) @(posedge clock);
               end
               1: begin
                  repeat ($urandom_range(16, 48)) begin
                     rsp_ready <= 1'($urandom_range(0, 1));
                     @(posedge clock);
                  end
               end
               2: begin
                  rsp_ready <= 1'b0;
                  repeat ($urandom_range(1, 8)) @(posedge clock);
               end
               default: begin
                  rsp_ready <= 1'b1;
                  repeat ($urandom_range(1, 10)) @(posedge clock);
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      trig_result_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (angle_queue.size() == 0) begin
            if (errors < 10)
               $display("unexpected response beat: angle %h invalid %b", rsp_angle, rsp_invalid);
            errors++;
         end else begin
            exp = angle_queue.pop_front();
            if (rsp_angle !== exp.angle || rsp_invalid !== exp.invalid) begin
               if (errors < 10)
                  $display("mismatch op %0d arg %h: angle exp %h got %h, invalid exp %b got %b",
                           exp.action, exp.arg, exp.angle, rsp_angle, exp.invalid, rsp_invalid);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[inverse_trig_unit] ERROR");
         $finish;
      end
   end

endmodule
